>>> rtl/core/kitw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kitw_pkg
// Shared constants, register codes, types and helper functions for the
// k-mer index to word converter.
// ----------------------------------------------------------------------------
package kitw_pkg;

    // limits of the conversion
    localparam int MAX_WORD  = 32;
    localparam int MAX_ALPHA = 24;

    // field and register widths
    localparam int IDX_W      = 32;
    localparam int RADIX_W    = 5;
    localparam int LEN_W      = 6;
    localparam int DIGIT_W    = 5;
    localparam int SYM_W      = 8;
    localparam int POS_W      = 5;
    localparam int ADDR_W     = $clog2(MAX_WORD);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 16;

    // divider: quotient bits resolved per cycle and shift steps per digit
    localparam int DIV_STEP  = 4;
    localparam int DIV_CYC   = IDX_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_MID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HI  = 3'd5;

    // request to the serial divider
    typedef struct packed {
        logic               start;
        logic [IDX_W-1:0]   dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    // result of the serial divider
    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_res;

    // radix clamped to 2..MAX_ALPHA
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_W'(2)) begin
            res = RADIX_W'(2);
        end else if (r > RADIX_W'(MAX_ALPHA)) begin
            res = RADIX_W'(MAX_ALPHA);
        end
        return res;
    endfunction

    // word length clamped to MAX_WORD
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
        logic [LEN_W-1:0] res;
        res = l;
        if (l > LEN_W'(MAX_WORD)) begin
            res = LEN_W'(MAX_WORD);
        end
        return res;
    endfunction

    // character code of a digit; bank three folds back onto bank zero
    function automatic logic [SYM_W-1:0] char_code(
        input logic [DIGIT_W-1:0]    d,
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] mid,
        input logic [CFG_DATA_W-1:0] hi
    );
        logic [CFG_DATA_W-1:0] bank;
        logic [2:0]            lane;
        unique case (d[4:3])
            2'd1:    bank = mid;
            2'd2:    bank = hi;
            default: bank = lo;
        endcase
        lane = d[2:0];
        return bank[{lane, 3'b000} +: SYM_W];
    endfunction

endpackage

>>> rtl/core/kitw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kitw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kitw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/kitw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kitw_div
// Digit-serial restoring divider: divides the 32-bit index by the radix,
// shifting four dividend bits through the remainder each cycle.
// ----------------------------------------------------------------------------
module kitw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kitw_pkg::t_div_req i_req,
    output kitw_pkg::t_div_res o_res
);
    import kitw_pkg::*;

    logic [IDX_W-1:0]     r_q;
    logic [IDX_W-1:0]     n_q;
    logic [DIGIT_W-1:0]   r_rem;
    logic [DIGIT_W-1:0]   n_rem;
    logic [RADIX_W-1:0]   r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // four restoring steps; remainder stays below the divisor
    always_comb begin
        logic [DIGIT_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEP; k++) begin
            trial = {n_rem, n_q[IDX_W-1]};
            n_q   = {n_q[IDX_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                n_rem  = DIGIT_W'(trial - {1'b0, r_div});
                n_q[0] = 1'b1;
            end else begin
                n_rem = trial[DIGIT_W-1:0];
            end
        end
    end

    // control: busy flag, step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_q;
    assign o_res.remainder = r_rem;

endmodule

>>> rtl/core/kmer_index_to_word.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_index_to_word
// Converts a k-mer index into its word of base-radix symbols, most
// significant first, one symbol per output transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) takes one 32-bit index per transfer. Master stream
//   (o_m_*) gives word_length symbols per index; tdata carries the symbol
//   and its position, tlast marks the final symbol of the word.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle; unused indexes are ignored.
// Datapath:
//   Digits come from a serial divider resolving four quotient bits a cycle
//   and go to a 32-entry digit RAM. Each symbol is then read back by a
//   registered RAM read, then an output register load. A zero length word
//   gives no output. One index is in flight at a time.
// Reset and stalls:
//   Synchronous reset restores radix 4, length 8, raw digit mode and zero
//   character tables, and empties the output register. When the receiver
//   stalls, the output register holds its symbol and readout waits.
// ----------------------------------------------------------------------------
module kmer_index_to_word (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [kitw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kitw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [kitw_pkg::IDX_W-1:0]        i_s_tdata,   // word_index
    // output stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [kitw_pkg::OUT_DATA_W-1:0]   o_m_tdata,   // symbol[7:0], position[12:8]
    output logic                              o_m_tlast    // last_symbol
);
    import kitw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_LD   = 2'd3;

    // configuration registers
    logic [RADIX_W-1:0]    r_radix;
    logic [LEN_W-1:0]      r_wlen;
    logic                  r_mode;
    logic [CFG_DATA_W-1:0] r_chars_lo;
    logic [CFG_DATA_W-1:0] r_chars_mid;
    logic [CFG_DATA_W-1:0] r_chars_hi;

    // sequencer
    logic [1:0]            r_state;
    logic [ADDR_W-1:0]     r_wa;
    logic [ADDR_W-1:0]     r_pos;
    logic [ADDR_W-1:0]     r_lastpos;

    // output register
    logic                  r_ovalid;
    logic [SYM_W-1:0]      r_osym;
    logic [POS_W-1:0]      r_opos;
    logic                  r_olast;

    logic [LEN_W-1:0]      len_eff;
    logic                  in_xfer;
    logic                  out_free;
    logic [DIGIT_W-1:0]    rd_digit;
    logic [SYM_W-1:0]      sym;
    t_div_req              div_req;
    t_div_res              div_res;

    assign len_eff    = eff_len(r_wlen);
    assign o_s_tready = (r_state == ST_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ovalid || i_m_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_W'(4);
            r_wlen      <= LEN_W'(8);
            r_mode      <= 1'b0;
            r_chars_lo  <= '0;
            r_chars_mid <= '0;
            r_chars_hi  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIX:     r_radix     <= i_cfg_data[RADIX_W-1:0];
                REG_WORD_LEN:  r_wlen      <= i_cfg_data[LEN_W-1:0];
                REG_ALPHA_MOD: r_mode      <= i_cfg_data[0];
                REG_CHARS_LO:  r_chars_lo  <= i_cfg_data;
                REG_CHARS_MID: r_chars_mid <= i_cfg_data;
                REG_CHARS_HI:  r_chars_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divider start: first digit from the input, later ones from the quotient
    always_comb begin
        div_req.divisor  = eff_radix(r_radix);
        div_req.dividend = i_s_tdata;
        div_req.start    = 1'b0;
        if (r_state == ST_IDLE) begin
            div_req.start = in_xfer && (len_eff != '0);
        end else if (r_state == ST_DIV) begin
            div_req.dividend = div_res.quotient;
            div_req.start    = div_res.done && (r_wa != '0);
        end
    end

    kitw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    // digit store, least significant digit written at the highest position
    kitw_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_WORD)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_DIV) && div_res.done),
        .i_waddr (r_wa),
        .i_wdata (div_res.remainder),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_pos),
        .o_rdata (rd_digit)
    );

    // symbol mapping
    assign sym = r_mode ? char_code(rd_digit, r_chars_lo, r_chars_mid, r_chars_hi)
                        : SYM_W'(rd_digit);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && (len_eff != '0)) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_res.done && (r_wa == '0)) begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    if (out_free) begin
                        r_state <= (r_pos == r_lastpos) ? ST_IDLE : ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // write and read pointers
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && in_xfer) begin
            r_wa      <= ADDR_W'(len_eff - LEN_W'(1));
            r_lastpos <= ADDR_W'(len_eff - LEN_W'(1));
            r_pos     <= '0;
        end else if ((r_state == ST_DIV) && div_res.done && (r_wa != '0)) begin
            r_wa <= r_wa - ADDR_W'(1);
        end else if ((r_state == ST_LD) && out_free) begin
            r_pos <= r_pos + ADDR_W'(1);
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_LD) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LD) && out_free) begin
            r_osym  <= sym;
            r_opos  <= POS_W'(r_pos);
            r_olast <= (r_pos == r_lastpos);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_DATA_W - SYM_W - POS_W){1'b0}}, r_opos, r_osym};
    assign o_m_tlast  = r_olast;

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-mer index to word converter. Index words
// are streamed in under random gaps and output back-pressure, and every
// symbol transfer is checked against a word predicted from the same
// register settings. The run steps through directed corner settings, then
// through phases of random settings and indexes.
// ----------------------------------------------------------------------------
module tb_top;
    import kitw_pkg::*;

    localparam int IDLE_PCT  = 13;
    localparam int HOLD_CYC  = 1000;
    localparam int DRAIN_CYC = 2 * (11 * MAX_WORD + 1);

    // spare register slots, writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [POS_W-1:0] position;
        logic             last_symbol;
    } t_symbol;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic [IDX_W-1:0]      s_data   = '0;
    logic                  m_valid;
    logic                  m_ready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_last;

    // shadow copy of the register file
    logic [RADIX_W-1:0]    cfg_radix  = 5'd4;
    logic [LEN_W-1:0]      cfg_length = 6'd8;
    logic                  cfg_alpha  = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_chars [3] = '{64'd0, 64'd0, 64'd0};

    logic [IDX_W-1:0] pending_index [$];
    t_symbol          expected_symbols [$];
    int               mismatch_cnt = 0;
    logic             calm         = 1'b0;
    logic             hold_arm     = 1'b0;
    logic             hold_done    = 1'b0;
    int               hold_left    = 0;

    kmer_index_to_word i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),     // word_index
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),     // symbol[7:0], position[12:8]
        .o_m_tlast  (m_last)      // last_symbol
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // radix and length as the converter really uses them
    function automatic int unsigned word_base();
        if (cfg_radix < 2) return 2;
        if (cfg_radix > MAX_ALPHA) return MAX_ALPHA;
        return cfg_radix;
    endfunction

    function automatic int unsigned word_len();
        if (cfg_length > MAX_WORD) return MAX_WORD;
        return cfg_length;
    endfunction

    // split an index into digits and queue the symbols it must produce
    function automatic void predict_word(input logic [IDX_W-1:0] word_index);
        logic [DIGIT_W-1:0]    digits [MAX_WORD];
        logic [CFG_DATA_W-1:0] bank;
        int unsigned           base;
        int unsigned           len;
        int unsigned           quot;
        t_symbol               sym;
        base = word_base();
        len  = word_len();
        quot = word_index;
        for (int i = len; i > 0; i--) begin
            digits[i-1] = DIGIT_W'(quot % base);
            quot        = quot / base;
        end
        for (int i = 0; i < len; i++) begin
            bank = cfg_chars[(digits[i] / 8) % 3];
            sym.symbol      = cfg_alpha ? bank[digits[i][2:0]*8 +: 8] : SYM_W'(digits[i]);
            sym.position    = POS_W'(i);
            sym.last_symbol = (i + 1 == len);
            expected_symbols.push_back(sym);
        end
    endfunction

    // random index, biased towards the wrap point radix^length
    function automatic logic [IDX_W-1:0] rand_index();
        logic [63:0] span;
        int unsigned kind;
        span = 64'd1;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < word_len(); i++) begin
            if (span <= 64'h1_0000_0000) span = span * word_base();
        end
        if (kind < 2) return IDX_W'($urandom_range(0, 255));
        if (kind < 4 && span <= 64'h1_0000_0000) return IDX_W'(span - 2 + $urandom_range(0, 3));
        if (kind == 4) return ~(IDX_W'(1) << $urandom_range(0, IDX_W - 1));
        if (kind == 5 && span <= 64'h1_0000_0000) begin
            return IDX_W'($urandom_range(0, 32'(span - 64'd1)));
        end
        return $urandom;
    endfunction

    // register write, shadow copy updated alongside
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            REG_RADIX:     cfg_radix  = value[RADIX_W-1:0];
            REG_WORD_LEN:  cfg_length = value[LEN_W-1:0];
            REG_ALPHA_MOD: cfg_alpha  = value[0];
            REG_CHARS_LO:  cfg_chars[0] = value;
            REG_CHARS_MID: cfg_chars[1] = value;
            REG_CHARS_HI:  cfg_chars[2] = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all indexes taken, all symbols seen, then let a zero-length word finish
    task automatic wait_idle();
        while (pending_index.size() != 0 || s_valid) @(posedge clk);
        while (expected_symbols.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_index.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_valid <= 1'b1;
                s_data  <= pending_index.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output receiver, with one long hold-off once armed
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // predict on each input transfer, check each output transfer
    always @(posedge clk) begin
        t_symbol want;
        if (rst_n) begin
            if (s_valid && s_ready) predict_word(s_data);
            if (m_valid && m_ready) begin
                if (expected_symbols.size() == 0) begin
                    $error("symbol transfer with nothing expected: tdata %h tlast %b",
                           m_data, m_last);
                    mismatch_cnt++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (m_data[7:0] !== want.symbol) begin
                        $error("symbol: expected %0d, actual %0d", want.symbol, m_data[7:0]);
                        mismatch_cnt++;
                    end
                    if (m_data[12:8] !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, m_data[12:8]);
                        mismatch_cnt++;
                    end
                    if (m_last !== want.last_symbol) begin
                        $error("last_symbol: expected %0d, actual %0d",
                               want.last_symbol, m_last);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // run watchdog
    initial begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus sequence
    initial begin
        int unsigned sel;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: radix 4, eight symbols, raw digits, wrap at 4^8
        pending_index = '{32'd0, 32'hFFFF_FFFF, 32'd65535, 32'd65536, 32'hA5A5_5A5A};
        wait_idle();

        // radix below two, full word, character table
        write_reg(REG_RADIX, 64'd0);
        write_reg(REG_WORD_LEN, 64'd32);
        write_reg(REG_ALPHA_MOD, 64'd1);
        write_reg(REG_CHARS_LO, {$urandom, $urandom});
        write_reg(REG_CHARS_MID, {$urandom, $urandom});
        write_reg(REG_CHARS_HI, {$urandom, $urandom});
        pending_index = '{32'd0, 32'hFFFF_FFFF, 32'h5555_5555};
        wait_idle();

        // radix and length above their limits, every table lane reachable
        write_reg(REG_RADIX, 64'd31);
        write_reg(REG_WORD_LEN, 64'd63);
        pending_index = '{32'hFFFF_FFFF, 32'd0, $urandom};
        wait_idle();

        // top radix, either side of the wrap at 24^6
        write_reg(REG_RADIX, 64'd24);
        write_reg(REG_WORD_LEN, 64'd6);
        pending_index = '{32'd191102975, 32'd191102976};
        wait_idle();

        // zero-length words give nothing
        write_reg(REG_WORD_LEN, 64'd0);
        pending_index = '{32'd0, 32'hFFFF_FFFF, 32'd12345};
        wait_idle();

        // spare slots ignored; single binary digit, raw mode
        write_reg(REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_SPARE_7, 64'h0000_0000_0000_0001);
        write_reg(REG_RADIX, 64'd2);
        write_reg(REG_WORD_LEN, 64'd1);
        write_reg(REG_ALPHA_MOD, 64'd0);
        pending_index = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF};
        wait_idle();

        // base three, wrap at 3^20
        write_reg(REG_RADIX, 64'd3);
        write_reg(REG_WORD_LEN, 64'd20);
        pending_index = '{32'hFFFF_FFFF, 32'd3486784400, 32'd3486784401};
        wait_idle();

        // random settings and indexes, mostly short words
        for (int ph = 0; ph < 7; ph++) begin
            sel = $urandom_range(0, 9);
            write_reg(REG_RADIX, 64'($urandom_range(0, 31)));
            write_reg(REG_WORD_LEN, (sel == 0) ? 64'($urandom_range(0, 63))
                                               : 64'($urandom_range(1, 12)));
            write_reg(REG_ALPHA_MOD, 64'($urandom_range(0, 1)));
            write_reg(REG_CHARS_LO, {$urandom, $urandom});
            write_reg(REG_CHARS_MID, {$urandom, $urandom});
            write_reg(REG_CHARS_HI, {$urandom, $urandom});
            calm = (ph == 2);
            for (int n = 0; n < 35; n++) pending_index.push_back(rand_index());
            if (ph == 4) begin
                @(posedge clk);
                hold_arm <= 1'b1;
            end
            wait_idle();
        end

        if (mismatch_cnt == 0 && expected_symbols.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
